[src/bcg_pkg.sv]
// ----------------------------------------------------------------------------
// Battery charge gauge package
// Shared constants, request codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bcg_pkg;

    localparam int LEVELS_DEF       = 10;
    localparam int SAMPLE_DEPTH_DEF = 256;

    localparam int MV_W   = 16;
    localparam int REQ_W  = 3;
    localparam int EIDX_W = 4;
    localparam int LVL_W  = 5;
    localparam int MODE_W = 2;
    localparam int ZF_W   = 8;
    localparam int CFG_W  = 3;

    localparam logic [REQ_W-1:0] REQ_SAMPLE = 3'd0;
    localparam logic [REQ_W-1:0] REQ_START  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_FINISH = 3'd2;
    localparam logic [REQ_W-1:0] REQ_WRITE  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

    localparam logic [CFG_W-1:0] CFG_CRITICAL  = 3'd0;
    localparam logic [CFG_W-1:0] CFG_FULL      = 3'd1;
    localparam logic [CFG_W-1:0] CFG_CHARGING  = 3'd2;
    localparam logic [CFG_W-1:0] CFG_POWER_OFF = 3'd3;
    localparam logic [CFG_W-1:0] CFG_ZERO_FRAC = 3'd4;

    localparam logic [MODE_W-1:0] MODE_ON       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CHARGING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ONLY_CHG = 2'd2;

    localparam logic [2:0] LVL_HOLD = 3'd0;
    localparam logic [2:0] LVL_ZERO = 3'd1;
    localparam logic [2:0] LVL_FULL = 3'd2;
    localparam logic [2:0] LVL_WALK = 3'd3;
    localparam logic [2:0] LVL_DIV  = 3'd4;

    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_LEVEL  = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;
    localparam logic [1:0] KIND_ENTRY  = 2'd3;

    typedef struct packed {
        logic       load_in;
        logic       apply;
        logic       walk_step;
        logic [2:0] lvl_sel;
        logic       mul;
        logic       div_load_lin;
        logic       prod;
        logic       div_load_fin;
        logic       div_step;
        logic       fin_init;
        logic       fin_next;
        logic       mem_rd;
        logic       out_load;
        logic [1:0] out_kind;
    } bcg_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             tbl_valid;
        logic             lin_low;
        logic             lin_high;
        logic             walk_done;
        logic             reject;
        logic             div_done;
        logic             fin_last;
        logic             out_free;
    } bcg_status_t;

endpackage

[src/bcg_ctrl.sv]
// ----------------------------------------------------------------------------
// Battery charge gauge controller
// Sequences each request through the datapath and the result register.
// ----------------------------------------------------------------------------
module bcg_ctrl
    import bcg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  bcg_status_t stat,
    output bcg_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_WALK   = 4'd2;
    localparam logic [3:0] ST_MUL    = 4'd3;
    localparam logic [3:0] ST_LLOAD  = 4'd4;
    localparam logic [3:0] ST_LDIV   = 4'd5;
    localparam logic [3:0] ST_RES    = 4'd6;
    localparam logic [3:0] ST_PROD   = 4'd7;
    localparam logic [3:0] ST_FLOAD  = 4'd8;
    localparam logic [3:0] ST_FDIV   = 4'd9;
    localparam logic [3:0] ST_FINIT  = 4'd10;
    localparam logic [3:0] ST_FRD    = 4'd11;
    localparam logic [3:0] ST_FEMIT  = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [1:0] kind_reg, kind_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.apply = 1'b1;
                kind_next = KIND_ACK;
                state_next = ST_RES;
                if (stat.req == REQ_SAMPLE) begin
                    kind_next = KIND_LEVEL;
                    if (stat.tbl_valid) begin
                        state_next = ST_WALK;
                    end else if (stat.lin_low) begin
                        cmd.lvl_sel = LVL_ZERO;
                    end else if (stat.lin_high) begin
                        cmd.lvl_sel = LVL_FULL;
                    end else begin
                        state_next = ST_MUL;
                    end
                end else if (stat.req == REQ_FINISH) begin
                    if (stat.reject) begin
                        kind_next = KIND_REJECT;
                    end else begin
                        state_next = ST_PROD;
                    end
                end
            end
            ST_WALK: begin
                if (stat.walk_done) begin
                    cmd.lvl_sel = LVL_WALK;
                    state_next  = ST_RES;
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_LLOAD;
            end
            ST_LLOAD: begin
                cmd.div_load_lin = 1'b1;
                state_next       = ST_LDIV;
            end
            ST_LDIV: begin
                if (stat.div_done) begin
                    cmd.lvl_sel = LVL_DIV;
                    state_next  = ST_RES;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_RES: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = kind_reg;
                    state_next   = ST_IDLE;
                end
            end
            ST_PROD: begin
                cmd.prod   = 1'b1;
                state_next = ST_FLOAD;
            end
            ST_FLOAD: begin
                cmd.div_load_fin = 1'b1;
                state_next       = ST_FDIV;
            end
            ST_FDIV: begin
                if (stat.div_done) begin
                    state_next = ST_FINIT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_FINIT: begin
                cmd.fin_init = 1'b1;
                state_next   = ST_FRD;
            end
            ST_FRD: begin
                cmd.mem_rd = 1'b1;
                state_next = ST_FEMIT;
            end
            ST_FEMIT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_ENTRY;
                    if (stat.fin_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.fin_next = 1'b1;
                        state_next   = ST_FRD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kind_reg  <= KIND_ACK;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

[src/bcg_datapath.sv]
// ----------------------------------------------------------------------------
// Battery charge gauge datapath
// Configuration, calibration state, sample store, level table, shared
// divider and the result register.
// ----------------------------------------------------------------------------
module bcg_datapath
    import bcg_pkg::*;
#(
    parameter int LEVELS       = LEVELS_DEF,
    parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_index,
    input  logic [MV_W-1:0]   cfg_data,
    input  logic [REQ_W-1:0]  s_req_type,
    input  logic [MV_W-1:0]   s_voltage_mv,
    input  logic [EIDX_W-1:0] s_entry_index,
    input  logic [MV_W-1:0]   s_entry_mv,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [LVL_W-1:0]  m_charge_level,
    output logic [MODE_W-1:0] m_power_mode,
    output logic              m_status,
    output logic [EIDX_W-1:0] m_table_index,
    output logic [MV_W-1:0]   m_table_mv,
    output logic              m_calibrating_flag,
    output logic              m_calibrated_flag,
    output logic              m_failed_flag,
    output logic              m_last,
    input  bcg_cmd_t          cmd,
    output bcg_status_t       stat
);

    localparam int CNT_W   = $clog2(SAMPLE_DEPTH + 1);
    localparam int ADDR_W  = $clog2(SAMPLE_DEPTH);
    localparam int FIN_DIV = 256 * LEVELS;
    localparam int FD_W    = $clog2(FIN_DIV + 1);
    localparam int NUM_W   = 22;
    localparam int DSH_W   = 26;
    localparam int Q_W     = 9;
    localparam int PROD_W  = 21;
    localparam int P_W     = 18;

    logic [MV_W-1:0] crit_reg, full_reg, chg_reg, poff_reg;
    logic [ZF_W-1:0] zf_reg;

    logic [REQ_W-1:0]  req_reg;
    logic [MV_W-1:0]   v_reg;
    logic [EIDX_W-1:0] eidx_reg;
    logic [MV_W-1:0]   emv_reg;

    logic [CNT_W-1:0] count_reg;
    logic capture_reg, open_reg, failed_reg, valid_reg;

    logic [MV_W-1:0] store_mem [SAMPLE_DEPTH];
    logic [MV_W-1:0] rd_data_reg;
    logic [MV_W-1:0] tbl_reg [LEVELS];

    logic [LVL_W-1:0]  walk_reg;
    logic [LVL_W-1:0]  level_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [P_W-1:0]    p_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [DSH_W-1:0]  dsh_reg;
    logic [Q_W-1:0]    q_reg;
    logic [3:0]        div_cnt_reg;

    logic [Q_W-1:0]  q0_reg;
    logic [FD_W-1:0] r0_reg;
    logic [Q_W-1:0]  idx_reg;
    logic [FD_W-1:0] remf_reg;
    logic [EIDX_W-1:0] fin_i_reg;

    logic              out_valid_reg;
    logic [LVL_W-1:0]  out_level_reg;
    logic [MODE_W-1:0] out_mode_reg;
    logic              out_status_reg;
    logic [EIDX_W-1:0] out_tidx_reg;
    logic [MV_W-1:0]   out_tmv_reg;
    logic              out_open_reg, out_valid_flag_reg, out_failed_reg, out_last_reg;

    logic [MODE_W-1:0] mode;
    logic              store_we;
    logic [MV_W-1:0]   span;
    logic [MV_W-1:0]   walk_entry;
    logic [FD_W:0]     remf_sum;
    logic              remf_carry;
    logic [Q_W-1:0]    idx_clamped;
    logic [DSH_W-1:0]  rem_ext;

    always_comb begin
        if (v_reg > poff_reg) begin
            mode = MODE_ONLY_CHG;
        end else if (v_reg > chg_reg) begin
            mode = MODE_CHARGING;
        end else begin
            mode = MODE_ON;
        end
    end

    assign store_we = cmd.apply && (req_reg == REQ_SAMPLE) && capture_reg
                      && (v_reg > crit_reg) && (mode == MODE_ON)
                      && (count_reg < CNT_W'(SAMPLE_DEPTH));
    assign span       = full_reg - crit_reg;
    assign walk_entry = tbl_reg[walk_reg[EIDX_W-1:0]];
    assign remf_sum   = {1'b0, remf_reg} + {1'b0, r0_reg};
    assign remf_carry = (remf_sum >= (FD_W+1)'(FIN_DIV));
    assign idx_clamped = (idx_reg >= Q_W'(count_reg)) ? Q_W'(count_reg - 1'b1) : idx_reg;
    assign rem_ext    = DSH_W'(rem_reg);

    assign stat.req       = req_reg;
    assign stat.tbl_valid = valid_reg;
    assign stat.lin_low   = (v_reg <= crit_reg);
    assign stat.lin_high  = (v_reg >= full_reg);
    assign stat.walk_done = (walk_reg == LVL_W'(LEVELS)) || (walk_entry <= v_reg);
    assign stat.reject    = !open_reg || (count_reg == '0) || failed_reg;
    assign stat.div_done  = (div_cnt_reg == '0);
    assign stat.fin_last  = (fin_i_reg == EIDX_W'(LEVELS - 1));
    assign stat.out_free  = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crit_reg <= 16'd3300;
            full_reg <= 16'd4200;
            chg_reg  <= 16'd4300;
            poff_reg <= 16'd4600;
            zf_reg   <= 8'd26;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CRITICAL:  crit_reg <= cfg_data;
                CFG_FULL:      full_reg <= cfg_data;
                CFG_CHARGING:  chg_reg  <= cfg_data;
                CFG_POWER_OFF: poff_reg <= cfg_data;
                CFG_ZERO_FRAC: zf_reg   <= cfg_data[ZF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            capture_reg <= 1'b0;
            open_reg    <= 1'b0;
            failed_reg  <= 1'b0;
            valid_reg   <= 1'b0;
        end else if (cmd.apply) begin
            case (req_reg)
                REQ_SAMPLE: begin
                    if (capture_reg) begin
                        if (v_reg <= crit_reg) begin
                            capture_reg <= 1'b0;
                        end else if (mode != MODE_ON) begin
                            failed_reg  <= 1'b1;
                            capture_reg <= 1'b0;
                        end else if (store_we) begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                end
                REQ_START: begin
                    failed_reg  <= 1'b0;
                    count_reg   <= '0;
                    capture_reg <= 1'b1;
                    open_reg    <= 1'b1;
                end
                REQ_FINISH: begin
                    capture_reg <= 1'b0;
                    open_reg    <= 1'b0;
                    if (!stat.reject) begin
                        valid_reg <= 1'b1;
                    end
                end
                REQ_WRITE: begin
                    if (32'(eidx_reg) < LEVELS) begin
                        valid_reg <= 1'b1;
                    end
                end
                REQ_CLEAR: begin
                    valid_reg <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_mem[count_reg[ADDR_W-1:0]] <= v_reg;
        end
        if (cmd.mem_rd) begin
            rd_data_reg <= store_mem[idx_clamped[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.apply && (req_reg == REQ_WRITE) && (32'(eidx_reg) < LEVELS)) begin
            tbl_reg[eidx_reg] <= emv_reg;
        end else if (cmd.out_load && (cmd.out_kind == KIND_ENTRY)) begin
            tbl_reg[fin_i_reg] <= rd_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            req_reg  <= s_req_type;
            v_reg    <= s_voltage_mv;
            eidx_reg <= s_entry_index;
            emv_reg  <= s_entry_mv;
            walk_reg <= '0;
        end else if (cmd.walk_step) begin
            walk_reg <= walk_reg + 1'b1;
        end
        case (cmd.lvl_sel)
            LVL_ZERO: level_reg <= '0;
            LVL_FULL: level_reg <= LVL_W'(LEVELS);
            LVL_WALK: level_reg <= LVL_W'(LEVELS) - walk_reg;
            LVL_DIV:  level_reg <= q_reg[LVL_W-1:0];
            default: begin
            end
        endcase
        if (cmd.mul) begin
            prod_reg <= PROD_W'(v_reg - crit_reg) * PROD_W'(LEVELS);
        end
        if (cmd.prod) begin
            p_reg <= P_W'(count_reg) * P_W'(9'd256 - 9'(zf_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_load_lin || cmd.div_load_fin) begin
            div_cnt_reg <= 4'(Q_W);
        end else if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_load_lin) begin
            rem_reg <= {prod_reg, 1'b0} + NUM_W'(span);
            dsh_reg <= DSH_W'({span, 1'b0}) << (Q_W - 1);
            q_reg   <= '0;
        end else if (cmd.div_load_fin) begin
            rem_reg <= NUM_W'(p_reg);
            dsh_reg <= DSH_W'(FIN_DIV) << (Q_W - 1);
            q_reg   <= '0;
        end else if (cmd.div_step) begin
            if (rem_ext >= dsh_reg) begin
                rem_reg <= rem_reg - dsh_reg[NUM_W-1:0];
                q_reg   <= {q_reg[Q_W-2:0], 1'b1};
            end else begin
                q_reg   <= {q_reg[Q_W-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fin_init) begin
            q0_reg    <= q_reg;
            r0_reg    <= rem_reg[FD_W-1:0];
            idx_reg   <= '0;
            remf_reg  <= '0;
            fin_i_reg <= '0;
        end else if (cmd.fin_next) begin
            idx_reg   <= idx_reg + q0_reg + Q_W'(remf_carry);
            remf_reg  <= remf_carry ? FD_W'(remf_sum - (FD_W+1)'(FIN_DIV)) : remf_sum[FD_W-1:0];
            fin_i_reg <= fin_i_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_level_reg      <= (cmd.out_kind == KIND_LEVEL) ? level_reg : '0;
            out_mode_reg       <= (cmd.out_kind == KIND_LEVEL) ? mode : MODE_ON;
            out_status_reg     <= (cmd.out_kind == KIND_REJECT);
            out_tidx_reg       <= (cmd.out_kind == KIND_ENTRY) ? fin_i_reg : '0;
            out_tmv_reg        <= (cmd.out_kind == KIND_ENTRY) ? rd_data_reg : '0;
            out_open_reg       <= open_reg;
            out_valid_flag_reg <= valid_reg;
            out_failed_reg     <= failed_reg;
            out_last_reg       <= (cmd.out_kind != KIND_ENTRY) || stat.fin_last;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_charge_level     = out_level_reg;
    assign m_power_mode       = out_mode_reg;
    assign m_status           = out_status_reg;
    assign m_table_index      = out_tidx_reg;
    assign m_table_mv         = out_tmv_reg;
    assign m_calibrating_flag = out_open_reg;
    assign m_calibrated_flag  = out_valid_flag_reg;
    assign m_failed_flag      = out_failed_reg;
    assign m_last             = out_last_reg;

endmodule

[src/battery_charge_gauge_calibrator.sv]
// ----------------------------------------------------------------------------
// Battery charge gauge calibrator
// Voltage based charge level and power mode, with calibration of the level
// table from a captured discharge run.
// A plain request is decoded and its result word loaded; a sample walks the
// level table when it is valid, else takes the linear scale, which is set by
// a 9-step shared divider, when it lies between the thresholds.
// A successful finish runs the shared divider, then loads its table words one
// by one from the sample store; a stalled result register holds this back.
// A new word can be taken in the cycle after the previous result is loaded.
// Reset clears control state and loads the configuration defaults.
// ----------------------------------------------------------------------------
module battery_charge_gauge_calibrator
    import bcg_pkg::*;
#(
    parameter int LEVELS       = LEVELS_DEF,
    parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_index,
    input  logic [MV_W-1:0]   cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [REQ_W-1:0]  s_req_type,
    input  logic [MV_W-1:0]   s_voltage_mv,
    input  logic [EIDX_W-1:0] s_entry_index,
    input  logic [MV_W-1:0]   s_entry_mv,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [LVL_W-1:0]  m_charge_level,
    output logic [MODE_W-1:0] m_power_mode,
    output logic              m_status,
    output logic [EIDX_W-1:0] m_table_index,
    output logic [MV_W-1:0]   m_table_mv,
    output logic              m_calibrating_flag,
    output logic              m_calibrated_flag,
    output logic              m_failed_flag,
    output logic              m_last
);

    bcg_cmd_t    cmd;
    bcg_status_t stat;

    bcg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bcg_datapath #(
        .LEVELS       (LEVELS),
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_req_type         (s_req_type),
        .s_voltage_mv       (s_voltage_mv),
        .s_entry_index      (s_entry_index),
        .s_entry_mv         (s_entry_mv),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_charge_level     (m_charge_level),
        .m_power_mode       (m_power_mode),
        .m_status           (m_status),
        .m_table_index      (m_table_index),
        .m_table_mv         (m_table_mv),
        .m_calibrating_flag (m_calibrating_flag),
        .m_calibrated_flag  (m_calibrated_flag),
        .m_failed_flag      (m_failed_flag),
        .m_last             (m_last),
        .cmd                (cmd),
        .stat               (stat)
    );

endmodule
